// ----- hdl/svid_pkg.sv -----
package svid_pkg;

  // Instruction format selector, bits [31:30]
  localparam logic [1:0] OP_BRANCH = 2'd0;
  localparam logic [1:0] OP_CALL   = 2'd1;
  localparam logic [1:0] OP_ALU    = 2'd2;
  localparam logic [1:0] OP_MEM    = 2'd3;

  // Format 2 op2 values that are implemented
  localparam logic [2:0] OP2_BICC  = 3'd2;
  localparam logic [2:0] OP2_SETHI = 3'd4;

  // Condition codes with special handling
  localparam logic [3:0] COND_NEVER  = 4'd0;
  localparam logic [3:0] COND_ALWAYS = 4'd8;

  // Execution unit
  localparam logic [1:0] UNIT_NONE = 2'd0;
  localparam logic [1:0] UNIT_IU   = 2'd1;
  localparam logic [1:0] UNIT_BPU  = 2'd2;
  localparam logic [1:0] UNIT_LSU  = 2'd3;

  // Opcodes outside the op3 space
  localparam logic [6:0] OPC_CALL  = 7'd64;
  localparam logic [6:0] OPC_BICC  = 7'd65;
  localparam logic [6:0] OPC_SETHI = 7'd66;

  // Memory access kinds
  localparam logic [3:0] MEM_NONE = 4'd0;
  localparam logic [3:0] MEM_LDSB = 4'd1;
  localparam logic [3:0] MEM_LDSH = 4'd2;
  localparam logic [3:0] MEM_LDUB = 4'd3;
  localparam logic [3:0] MEM_LDUH = 4'd4;
  localparam logic [3:0] MEM_LD   = 4'd5;
  localparam logic [3:0] MEM_LDD  = 4'd6;
  localparam logic [3:0] MEM_STB  = 4'd7;
  localparam logic [3:0] MEM_STH  = 4'd8;
  localparam logic [3:0] MEM_ST   = 4'd9;
  localparam logic [3:0] MEM_STD  = 4'd10;

  // Load/store op3 codes
  localparam logic [5:0] OP3_LD    = 6'h00;
  localparam logic [5:0] OP3_LDUB  = 6'h01;
  localparam logic [5:0] OP3_LDUH  = 6'h02;
  localparam logic [5:0] OP3_LDD   = 6'h03;
  localparam logic [5:0] OP3_ST    = 6'h04;
  localparam logic [5:0] OP3_STB   = 6'h05;
  localparam logic [5:0] OP3_STH   = 6'h06;
  localparam logic [5:0] OP3_STD   = 6'h07;
  localparam logic [5:0] OP3_LDSB  = 6'h09;
  localparam logic [5:0] OP3_LDSH  = 6'h0A;

  // ALU-format op3 codes
  localparam logic [5:0] OP3_ADD     = 6'h00;
  localparam logic [5:0] OP3_AND     = 6'h01;
  localparam logic [5:0] OP3_OR      = 6'h02;
  localparam logic [5:0] OP3_XOR     = 6'h03;
  localparam logic [5:0] OP3_SUB     = 6'h04;
  localparam logic [5:0] OP3_ANDN    = 6'h05;
  localparam logic [5:0] OP3_ORN     = 6'h06;
  localparam logic [5:0] OP3_XNOR    = 6'h07;
  localparam logic [5:0] OP3_ADDX    = 6'h08;
  localparam logic [5:0] OP3_SUBX    = 6'h0C;
  localparam logic [5:0] OP3_ADDCC   = 6'h10;
  localparam logic [5:0] OP3_ANDCC   = 6'h11;
  localparam logic [5:0] OP3_ORCC    = 6'h12;
  localparam logic [5:0] OP3_XORCC   = 6'h13;
  localparam logic [5:0] OP3_SUBCC   = 6'h14;
  localparam logic [5:0] OP3_ANDNCC  = 6'h15;
  localparam logic [5:0] OP3_ORNCC   = 6'h16;
  localparam logic [5:0] OP3_XNORCC  = 6'h17;
  localparam logic [5:0] OP3_ADDXCC  = 6'h18;
  localparam logic [5:0] OP3_SUBXCC  = 6'h1C;
  localparam logic [5:0] OP3_TADDCC  = 6'h20;
  localparam logic [5:0] OP3_TSUBCC  = 6'h21;
  localparam logic [5:0] OP3_MULSCC  = 6'h24;
  localparam logic [5:0] OP3_SLL     = 6'h25;
  localparam logic [5:0] OP3_SRL     = 6'h26;
  localparam logic [5:0] OP3_SRA     = 6'h27;
  localparam logic [5:0] OP3_RDY     = 6'h28;
  localparam logic [5:0] OP3_RDPSR   = 6'h29;
  localparam logic [5:0] OP3_WRY     = 6'h30;
  localparam logic [5:0] OP3_WRPSR   = 6'h31;
  localparam logic [5:0] OP3_JMPL    = 6'h38;
  localparam logic [5:0] OP3_TICC    = 6'h3A;
  localparam logic [5:0] OP3_SAVE    = 6'h3C;
  localparam logic [5:0] OP3_RESTORE = 6'h3D;

  // rd field use
  localparam logic [1:0] DEST_NONE  = 2'd0;
  localparam logic [1:0] DEST_READ  = 2'd1;
  localparam logic [1:0] DEST_WRITE = 2'd2;

  // flag_use bits
  localparam logic [3:0] FL_PSR_RD = 4'b0001;
  localparam logic [3:0] FL_PSR_WR = 4'b0010;
  localparam logic [3:0] FL_Y_RD   = 4'b0100;
  localparam logic [3:0] FL_Y_WR   = 4'b1000;

  localparam logic [4:0] REG_LINK = 5'd15;

  typedef struct packed {
    logic       bad;
    logic [1:0] unit;
    logic [6:0] opcode;
    logic [3:0] mem_access;
    logic       src1_valid;
    logic [4:0] src1_reg;
    logic       src2_valid;
    logic [4:0] src2_reg;
    logic [1:0] dest_mode;
    logic [4:0] dest_reg;
    logic       dest_pair;
    logic [3:0] flag_use;
  } decode_t;

endpackage

// ----- hdl/sparc_v8_integer_decoder.sv -----
// Integer-subset instruction decoder, two register stages.
// An input transfer loads the instruction register; its decode then loads the result register.
// Throughput: one instruction per cycle while the output is not stalled; the decode cone
// lies between the instruction register and the result register.
// Reset (rst, synchronous, active high) empties both stages; no data is cleared.
module sparc_v8_integer_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instr_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        bad,
  output logic [1:0]  unit,
  output logic [6:0]  opcode,
  output logic [3:0]  mem_access,
  output logic        src1_valid,
  output logic [4:0]  src1_reg,
  output logic        src2_valid,
  output logic [4:0]  src2_reg,
  output logic [1:0]  dest_mode,
  output logic [4:0]  dest_reg,
  output logic        dest_pair,
  output logic [3:0]  flag_use
);

  // Stage 1 holds the raw word, stage 2 holds the decode result.
  logic               word_valid;
  logic [31:0]        word;
  svid_pkg::decode_t  dec_next;
  svid_pkg::decode_t  result;

  logic out_adv;   // result register may load
  logic word_adv;  // instruction register may load

  // A stage advances when it is empty or the stage after it moves on,
  // so a waiting result blocks a new transfer only once stage 1 is full too.
  assign out_adv  = !out_valid || !out_stall;
  assign word_adv = !word_valid || out_adv;
  assign in_stall = !word_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (word_adv) begin
      word_valid <= in_valid;
    end
  end

  // Hold the word when no transfer happens.
  always_ff @(posedge clk) begin
    if (word_adv && in_valid) begin
      word <= instr_word;
    end
  end

  svid_decode u_decode (
    .word (word),
    .dec  (dec_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= word_valid;
    end
  end

  // Capture the decode only for a live word; a stalled result holds.
  always_ff @(posedge clk) begin
    if (out_adv && word_valid) begin
      result <= dec_next;
    end
  end

  assign bad        = result.bad;
  assign unit       = result.unit;
  assign opcode     = result.opcode;
  assign mem_access = result.mem_access;
  assign src1_valid = result.src1_valid;
  assign src1_reg   = result.src1_reg;
  assign src2_valid = result.src2_valid;
  assign src2_reg   = result.src2_reg;
  assign dest_mode  = result.dest_mode;
  assign dest_reg   = result.dest_reg;
  assign dest_pair  = result.dest_pair;
  assign flag_use   = result.flag_use;

endmodule

// ----- hdl/svid_decode.sv -----
module svid_decode (
  input  logic [31:0]            word,
  output svid_pkg::decode_t      dec
);

  logic [1:0] op;
  logic [4:0] rd;
  logic [3:0] cond;
  logic [2:0] op2;
  logic [5:0] op3;
  logic       ok;
  logic       src;
  logic [1:0] dmode;
  logic       pair;
  logic [4:0] dreg;

  assign op   = word[31:30];
  assign rd   = word[29:25];
  assign cond = word[28:25];
  assign op2  = word[24:22];
  assign op3  = word[24:19];

  always_comb begin
    dec   = '0;
    ok    = 1'b1;
    src   = 1'b0;
    dmode = svid_pkg::DEST_NONE;
    pair  = 1'b0;
    dreg  = rd;

    unique case (op)
      svid_pkg::OP_CALL: begin
        dec.unit   = svid_pkg::UNIT_BPU;
        dec.opcode = svid_pkg::OPC_CALL;
        dmode      = svid_pkg::DEST_WRITE;
        dreg       = svid_pkg::REG_LINK;
      end
      svid_pkg::OP_BRANCH: begin
        unique case (op2)
          svid_pkg::OP2_BICC: begin
            dec.unit   = svid_pkg::UNIT_BPU;
            dec.opcode = svid_pkg::OPC_BICC;
            if (cond != svid_pkg::COND_ALWAYS && cond != svid_pkg::COND_NEVER) begin
              dec.flag_use = svid_pkg::FL_PSR_RD;
            end
          end
          svid_pkg::OP2_SETHI: begin
            dec.unit   = svid_pkg::UNIT_IU;
            dec.opcode = svid_pkg::OPC_SETHI;
            dmode      = svid_pkg::DEST_WRITE;
          end
          default: ok = 1'b0;
        endcase
      end
      svid_pkg::OP_MEM: begin
        dec.unit   = svid_pkg::UNIT_LSU;
        dec.opcode = {1'b0, op3};
        src        = 1'b1;
        dmode      = svid_pkg::DEST_WRITE;
        unique case (op3)
          svid_pkg::OP3_LDSB: dec.mem_access = svid_pkg::MEM_LDSB;
          svid_pkg::OP3_LDSH: dec.mem_access = svid_pkg::MEM_LDSH;
          svid_pkg::OP3_LDUB: dec.mem_access = svid_pkg::MEM_LDUB;
          svid_pkg::OP3_LDUH: dec.mem_access = svid_pkg::MEM_LDUH;
          svid_pkg::OP3_LD:   dec.mem_access = svid_pkg::MEM_LD;
          svid_pkg::OP3_LDD: begin
            dec.mem_access = svid_pkg::MEM_LDD;
            pair           = 1'b1;
          end
          svid_pkg::OP3_STB: begin
            dec.mem_access = svid_pkg::MEM_STB;
            dmode          = svid_pkg::DEST_READ;
          end
          svid_pkg::OP3_STH: begin
            dec.mem_access = svid_pkg::MEM_STH;
            dmode          = svid_pkg::DEST_READ;
          end
          svid_pkg::OP3_ST: begin
            dec.mem_access = svid_pkg::MEM_ST;
            dmode          = svid_pkg::DEST_READ;
          end
          svid_pkg::OP3_STD: begin
            dec.mem_access = svid_pkg::MEM_STD;
            dmode          = svid_pkg::DEST_READ;
            pair           = 1'b1;
          end
          default: ok = 1'b0;
        endcase
      end
      default: begin
        // arithmetic, logic, shift, state register and control transfer
        dec.unit   = svid_pkg::UNIT_IU;
        dec.opcode = {1'b0, op3};
        src        = 1'b1;
        dmode      = svid_pkg::DEST_WRITE;
        unique case (op3) inside
          svid_pkg::OP3_ADD, svid_pkg::OP3_AND, svid_pkg::OP3_OR, svid_pkg::OP3_XOR,
          svid_pkg::OP3_SUB, svid_pkg::OP3_ANDN, svid_pkg::OP3_ORN, svid_pkg::OP3_XNOR,
          svid_pkg::OP3_SLL, svid_pkg::OP3_SRL, svid_pkg::OP3_SRA,
          svid_pkg::OP3_SAVE, svid_pkg::OP3_RESTORE: ;
          svid_pkg::OP3_ADDX, svid_pkg::OP3_SUBX:
            dec.flag_use = svid_pkg::FL_PSR_RD;
          svid_pkg::OP3_ADDCC, svid_pkg::OP3_ANDCC, svid_pkg::OP3_ORCC,
          svid_pkg::OP3_XORCC, svid_pkg::OP3_SUBCC, svid_pkg::OP3_ANDNCC,
          svid_pkg::OP3_ORNCC, svid_pkg::OP3_XNORCC,
          svid_pkg::OP3_TADDCC, svid_pkg::OP3_TSUBCC:
            dec.flag_use = svid_pkg::FL_PSR_WR;
          svid_pkg::OP3_ADDXCC, svid_pkg::OP3_SUBXCC:
            dec.flag_use = svid_pkg::FL_PSR_RD | svid_pkg::FL_PSR_WR;
          svid_pkg::OP3_MULSCC:
            dec.flag_use = svid_pkg::FL_PSR_RD | svid_pkg::FL_PSR_WR
                         | svid_pkg::FL_Y_RD | svid_pkg::FL_Y_WR;
          svid_pkg::OP3_JMPL:
            dec.unit = svid_pkg::UNIT_BPU;
          svid_pkg::OP3_RDY: begin
            dec.flag_use = svid_pkg::FL_Y_RD;
            src          = 1'b0;
          end
          svid_pkg::OP3_RDPSR: begin
            dec.flag_use = svid_pkg::FL_PSR_RD;
            src          = 1'b0;
          end
          svid_pkg::OP3_WRY: begin
            dec.flag_use = svid_pkg::FL_Y_WR;
            dmode        = svid_pkg::DEST_NONE;
          end
          svid_pkg::OP3_WRPSR: begin
            dec.flag_use = svid_pkg::FL_PSR_WR;
            dmode        = svid_pkg::DEST_NONE;
          end
          svid_pkg::OP3_TICC: begin
            // only trap-always is implemented
            ok       = (cond == svid_pkg::COND_ALWAYS);
            dec.unit = svid_pkg::UNIT_BPU;
            src      = 1'b0;
            dmode    = svid_pkg::DEST_NONE;
          end
          default: ok = 1'b0;
        endcase
      end
    endcase

    if (src) begin
      dec.src1_valid = 1'b1;
      dec.src1_reg   = word[18:14];
      if (!word[13]) begin
        dec.src2_valid = 1'b1;
        dec.src2_reg   = word[4:0];
      end
    end
    if (dmode != svid_pkg::DEST_NONE) begin
      dec.dest_mode = dmode;
      dec.dest_reg  = pair ? {dreg[4:1], 1'b0} : dreg;
      dec.dest_pair = pair;
    end

    if (!ok) begin
      dec     = '0;
      dec.bad = 1'b1;
    end
  end

endmodule

// ----- hdl/svid_checker.sv -----
module svid_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        bad,
  input logic [1:0]  unit,
  input logic [6:0]  opcode,
  input logic [3:0]  mem_access,
  input logic        src1_valid,
  input logic [4:0]  src1_reg,
  input logic        src2_valid,
  input logic [4:0]  src2_reg,
  input logic [1:0]  dest_mode,
  input logic [4:0]  dest_reg,
  input logic        dest_pair,
  input logic [3:0]  flag_use
);

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({bad, unit, opcode, mem_access,
      src1_valid, src1_reg, src2_valid, src2_reg, dest_mode, dest_reg, dest_pair,
      flag_use}))
    else $error("stalled result changed");

  // A bad instruction carries no other decode.
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad |-> unit == svid_pkg::UNIT_NONE && opcode == '0
      && mem_access == svid_pkg::MEM_NONE && !src1_valid && !src2_valid
      && dest_mode == svid_pkg::DEST_NONE && !dest_pair && flag_use == '0)
    else $error("bad instruction with decode fields set");

  // Register pairs only for double accesses, always on an even register.
  a_pair_even: assert property (@(posedge clk) disable iff (rst)
    out_valid && dest_pair |-> !dest_reg[0]
      && (mem_access == svid_pkg::MEM_LDD || mem_access == svid_pkg::MEM_STD))
    else $error("register pair on odd register or non-double access");

  // Unused register fields read as zero.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (src1_valid || src1_reg == '0) && (src2_valid || src2_reg == '0)
      && (dest_mode != svid_pkg::DEST_NONE || dest_reg == '0))
    else $error("unused register field not zero");

endmodule

bind sparc_v8_integer_decoder svid_checker u_svid_checker (.*);

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Encodings that the package leaves out but the stimulus needs by name
  localparam logic [2:0] OP2_UNIMP  = 3'd0;
  localparam logic [2:0] OP2_RSV1   = 3'd1;
  localparam logic [2:0] OP2_RSV3   = 3'd3;
  localparam logic [2:0] OP2_RSV5   = 3'd5;
  localparam logic [2:0] OP2_FBFCC  = 3'd6;
  localparam logic [2:0] OP2_CBCCC  = 3'd7;
  localparam logic [3:0] COND_EQUAL = 4'd1;
  localparam logic [3:0] COND_VC    = 4'd15;
  localparam logic [5:0] OP3_LDA    = 6'h10;
  localparam logic [5:0] OP3_LDSTUB = 6'h0D;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 50;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

  // One accepted instruction and the decode it must produce
  typedef struct {
    logic [31:0]       word;
    svid_pkg::decode_t want;
  } decode_expect_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] instr_word;
  logic        out_valid;
  logic        out_stall;
  logic        bad;
  logic [1:0]  unit;
  logic [6:0]  opcode;
  logic [3:0]  mem_access;
  logic        src1_valid;
  logic [4:0]  src1_reg;
  logic        src2_valid;
  logic [4:0]  src2_reg;
  logic [1:0]  dest_mode;
  logic [4:0]  dest_reg;
  logic        dest_pair;
  logic [3:0]  flag_use;

  decode_expect_t expected_decodes [$];
  int unsigned    mismatch_count;
  int unsigned    cycle_count;

  // Sender pacing: bursts of random length, gaps of random length bounded by gap_max
  int unsigned gap_max;
  int unsigned burst_left;

  // Receiver behavior, set by the test tasks and read by the stall driver
  stall_mode_t stall_mode;
  int unsigned hold_len;
  bit          hold_ask;

  // Implemented format-3 operations, used to bias random words toward legal ones
  logic [5:0] mem_op3s [10] = '{svid_pkg::OP3_LD, svid_pkg::OP3_LDUB, svid_pkg::OP3_LDUH,
                                svid_pkg::OP3_LDD, svid_pkg::OP3_ST, svid_pkg::OP3_STB,
                                svid_pkg::OP3_STH, svid_pkg::OP3_STD, svid_pkg::OP3_LDSB,
                                svid_pkg::OP3_LDSH};
  logic [5:0] alu_op3s [34] = '{svid_pkg::OP3_ADD, svid_pkg::OP3_AND, svid_pkg::OP3_OR,
                                svid_pkg::OP3_XOR, svid_pkg::OP3_SUB, svid_pkg::OP3_ANDN,
                                svid_pkg::OP3_ORN, svid_pkg::OP3_XNOR, svid_pkg::OP3_ADDX,
                                svid_pkg::OP3_SUBX, svid_pkg::OP3_ADDCC,
                                svid_pkg::OP3_ANDCC, svid_pkg::OP3_ORCC,
                                svid_pkg::OP3_XORCC, svid_pkg::OP3_SUBCC,
                                svid_pkg::OP3_ANDNCC, svid_pkg::OP3_ORNCC,
                                svid_pkg::OP3_XNORCC, svid_pkg::OP3_ADDXCC,
                                svid_pkg::OP3_SUBXCC, svid_pkg::OP3_TADDCC,
                                svid_pkg::OP3_TSUBCC, svid_pkg::OP3_MULSCC,
                                svid_pkg::OP3_SLL, svid_pkg::OP3_SRL, svid_pkg::OP3_SRA,
                                svid_pkg::OP3_RDY, svid_pkg::OP3_RDPSR, svid_pkg::OP3_WRY,
                                svid_pkg::OP3_WRPSR, svid_pkg::OP3_JMPL,
                                svid_pkg::OP3_TICC, svid_pkg::OP3_SAVE,
                                svid_pkg::OP3_RESTORE};

  sparc_v8_integer_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .instr_word (instr_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .bad        (bad),
    .unit       (unit),
    .opcode     (opcode),
    .mem_access (mem_access),
    .src1_valid (src1_valid),
    .src1_reg   (src1_reg),
    .src2_valid (src2_valid),
    .src2_reg   (src2_reg),
    .dest_mode  (dest_mode),
    .dest_reg   (dest_reg),
    .dest_pair  (dest_pair),
    .flag_use   (flag_use)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Compute the decode of one instruction word for the integer subset
  function automatic svid_pkg::decode_t predict_decode(logic [31:0] w);
    svid_pkg::decode_t d;
    logic [1:0] op;
    logic [4:0] rd;
    logic [3:0] cond;
    logic [2:0] op2;
    logic [5:0] op3;
    logic       ok;
    logic       pair;
    logic       reads_src;
    logic [1:0] mode;
    d         = '0;
    op        = w[31:30];
    rd        = w[29:25];
    cond      = w[28:25];
    op2       = w[24:22];
    op3       = w[24:19];
    ok        = 1'b1;
    pair      = 1'b0;
    reads_src = 1'b0;
    mode      = svid_pkg::DEST_NONE;
    case (op)
      svid_pkg::OP_CALL: begin
        // CALL writes the link register, nothing else
        d.unit   = svid_pkg::UNIT_BPU;
        d.opcode = svid_pkg::OPC_CALL;
        mode     = svid_pkg::DEST_WRITE;
        rd       = svid_pkg::REG_LINK;
      end
      svid_pkg::OP_BRANCH: begin
        if (op2 == svid_pkg::OP2_BICC) begin
          d.unit   = svid_pkg::UNIT_BPU;
          d.opcode = svid_pkg::OPC_BICC;
          // Only conditional branches look at the condition codes
          if (cond != svid_pkg::COND_ALWAYS && cond != svid_pkg::COND_NEVER)
            d.flag_use = svid_pkg::FL_PSR_RD;
        end else if (op2 == svid_pkg::OP2_SETHI) begin
          d.unit   = svid_pkg::UNIT_IU;
          d.opcode = svid_pkg::OPC_SETHI;
          mode     = svid_pkg::DEST_WRITE;
        end else begin
          ok = 1'b0;
        end
      end
      svid_pkg::OP_MEM: begin
        d.unit    = svid_pkg::UNIT_LSU;
        d.opcode  = {1'b0, op3};
        reads_src = 1'b1;
        mode      = svid_pkg::DEST_WRITE;
        case (op3)
          svid_pkg::OP3_LDSB: d.mem_access = svid_pkg::MEM_LDSB;
          svid_pkg::OP3_LDSH: d.mem_access = svid_pkg::MEM_LDSH;
          svid_pkg::OP3_LDUB: d.mem_access = svid_pkg::MEM_LDUB;
          svid_pkg::OP3_LDUH: d.mem_access = svid_pkg::MEM_LDUH;
          svid_pkg::OP3_LD:   d.mem_access = svid_pkg::MEM_LD;
          svid_pkg::OP3_LDD: begin
            d.mem_access = svid_pkg::MEM_LDD;
            pair         = 1'b1;
          end
          svid_pkg::OP3_STB: begin
            d.mem_access = svid_pkg::MEM_STB;
            mode         = svid_pkg::DEST_READ;
          end
          svid_pkg::OP3_STH: begin
            d.mem_access = svid_pkg::MEM_STH;
            mode         = svid_pkg::DEST_READ;
          end
          svid_pkg::OP3_ST: begin
            d.mem_access = svid_pkg::MEM_ST;
            mode         = svid_pkg::DEST_READ;
          end
          svid_pkg::OP3_STD: begin
            d.mem_access = svid_pkg::MEM_STD;
            mode         = svid_pkg::DEST_READ;
            pair         = 1'b1;
          end
          default: ok = 1'b0;
        endcase
      end
      svid_pkg::OP_ALU: begin
        d.unit    = svid_pkg::UNIT_IU;
        d.opcode  = {1'b0, op3};
        reads_src = 1'b1;
        mode      = svid_pkg::DEST_WRITE;
        case (op3)
          svid_pkg::OP3_ADD, svid_pkg::OP3_AND, svid_pkg::OP3_OR, svid_pkg::OP3_XOR,
          svid_pkg::OP3_SUB, svid_pkg::OP3_ANDN, svid_pkg::OP3_ORN, svid_pkg::OP3_XNOR,
          svid_pkg::OP3_SLL, svid_pkg::OP3_SRL, svid_pkg::OP3_SRA,
          svid_pkg::OP3_SAVE, svid_pkg::OP3_RESTORE: ;
          svid_pkg::OP3_ADDX, svid_pkg::OP3_SUBX: d.flag_use = svid_pkg::FL_PSR_RD;
          svid_pkg::OP3_ADDCC, svid_pkg::OP3_ANDCC, svid_pkg::OP3_ORCC,
          svid_pkg::OP3_XORCC, svid_pkg::OP3_SUBCC, svid_pkg::OP3_ANDNCC,
          svid_pkg::OP3_ORNCC, svid_pkg::OP3_XNORCC, svid_pkg::OP3_TADDCC,
          svid_pkg::OP3_TSUBCC:
            d.flag_use = svid_pkg::FL_PSR_WR;
          svid_pkg::OP3_ADDXCC, svid_pkg::OP3_SUBXCC:
            d.flag_use = svid_pkg::FL_PSR_RD | svid_pkg::FL_PSR_WR;
          svid_pkg::OP3_MULSCC:
            d.flag_use = svid_pkg::FL_PSR_RD | svid_pkg::FL_PSR_WR
                       | svid_pkg::FL_Y_RD | svid_pkg::FL_Y_WR;
          svid_pkg::OP3_JMPL: d.unit = svid_pkg::UNIT_BPU;
          svid_pkg::OP3_RDY: begin
            d.flag_use = svid_pkg::FL_Y_RD;
            reads_src  = 1'b0;
          end
          svid_pkg::OP3_RDPSR: begin
            d.flag_use = svid_pkg::FL_PSR_RD;
            reads_src  = 1'b0;
          end
          svid_pkg::OP3_WRY: begin
            d.flag_use = svid_pkg::FL_Y_WR;
            mode       = svid_pkg::DEST_NONE;
          end
          svid_pkg::OP3_WRPSR: begin
            d.flag_use = svid_pkg::FL_PSR_WR;
            mode       = svid_pkg::DEST_NONE;
          end
          svid_pkg::OP3_TICC: begin
            // Only trap-always is implemented; it uses no registers at all
            if (cond == svid_pkg::COND_ALWAYS) begin
              d.unit    = svid_pkg::UNIT_BPU;
              reads_src = 1'b0;
              mode      = svid_pkg::DEST_NONE;
            end else begin
              ok = 1'b0;
            end
          end
          default: ok = 1'b0;
        endcase
      end
    endcase
    if (reads_src) begin
      d.src1_valid = 1'b1;
      d.src1_reg   = w[18:14];
      if (!w[13]) begin
        d.src2_valid = 1'b1;
        d.src2_reg   = w[4:0];
      end
    end
    if (mode != svid_pkg::DEST_NONE) begin
      d.dest_mode = mode;
      d.dest_reg  = pair ? {rd[4:1], 1'b0} : rd;
      d.dest_pair = pair;
    end
    // A bad instruction reports nothing but the bad flag
    if (!ok) begin
      d     = '0;
      d.bad = 1'b1;
    end
    return d;
  endfunction

  // Draw a word that is mostly a legal integer instruction with random fields
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    int unsigned pick;
    w    = $urandom;
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      w[31:30] = svid_pkg::OP_MEM;
      w[24:19] = mem_op3s[$urandom_range(9, 0)];
    end else if (pick < 70) begin
      w[31:30] = svid_pkg::OP_ALU;
      w[24:19] = alu_op3s[$urandom_range(33, 0)];
      // Give trap-always a fair share against the other trap conditions
      if (w[24:19] == svid_pkg::OP3_TICC && $urandom_range(1, 0) == 1)
        w[28:25] = svid_pkg::COND_ALWAYS;
    end else if (pick < 82) begin
      w[31:30] = svid_pkg::OP_BRANCH;
      if ($urandom_range(2, 0) != 0)
        w[24:22] = ($urandom_range(1, 0) == 1) ? svid_pkg::OP2_BICC : svid_pkg::OP2_SETHI;
    end else if (pick < 88) begin
      w[31:30] = svid_pkg::OP_CALL;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] word, int unsigned got,
                                 int unsigned want);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] %s: word %h got %0d want %0d", $realtime, what, word, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] word, logic [7:0] got,
                             logic [7:0] want);
    if (got !== want) report_mismatch(name, word, 32'(got), 32'(want));
  endtask

  // Offer one instruction, hold it until the transfer, then apply burst pacing.
  // Entered and left just after a falling edge.
  task automatic send_instr(input logic [31:0] w);
    decode_expect_t e;
    int unsigned    gap;
    e.word     = w;
    e.want     = predict_decode(w);
    in_valid   <= 1'b1;
    instr_word <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_decodes.push_back(e);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap > 0) begin
        // Drop valid for the gap; the payload is free to stay as it is
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Hold the input idle until every outstanding decode has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_decodes.size() != 0) @(negedge clk);
  endtask

  // Extremes of the fields and each special case of the decode, at full rate
  task automatic test_special_cases();
    gap_max    = 0;
    stall_mode = STALL_NONE;
    send_instr({svid_pkg::OP_BRANCH, 5'd0, OP2_UNIMP, 22'd0});
    send_instr(32'hFFFF_FFFF);
    send_instr({svid_pkg::OP_CALL, 30'd0});
    send_instr({svid_pkg::OP_CALL, {30{1'b1}}});
    send_instr({svid_pkg::OP_BRANCH, 5'd31, svid_pkg::OP2_SETHI, 22'h3F_FFFF});
    // Branch-always and branch-never leave the PSR alone, the others read it
    send_instr({svid_pkg::OP_BRANCH, 1'b0, svid_pkg::COND_ALWAYS, svid_pkg::OP2_BICC,
                22'h00_0001});
    send_instr({svid_pkg::OP_BRANCH, 1'b1, svid_pkg::COND_NEVER, svid_pkg::OP2_BICC,
                22'h00_0000});
    send_instr({svid_pkg::OP_BRANCH, 1'b1, COND_EQUAL, svid_pkg::OP2_BICC, 22'h2A_AAAA});
    send_instr({svid_pkg::OP_BRANCH, 1'b0, COND_VC, svid_pkg::OP2_BICC, 22'h15_5555});
    // Unimplemented format-2 encodings, float and coprocessor branches
    send_instr({svid_pkg::OP_BRANCH, 5'd17, OP2_RSV1, 22'h3F_FFFF});
    send_instr({svid_pkg::OP_BRANCH, 5'd3, OP2_RSV3, 22'h12_3456});
    send_instr({svid_pkg::OP_BRANCH, 5'd28, OP2_RSV5, 22'h0A_BCDE});
    send_instr({svid_pkg::OP_BRANCH, 5'd8, OP2_FBFCC, 22'h00_0010});
    send_instr({svid_pkg::OP_BRANCH, 5'd8, OP2_CBCCC, 22'h00_0020});
    // Trap-always, with and without the annul position set, and a bad trap
    send_instr({svid_pkg::OP_ALU, 1'b0, svid_pkg::COND_ALWAYS, svid_pkg::OP3_TICC, 5'd7,
                1'b1, 13'h007F});
    send_instr({svid_pkg::OP_ALU, 1'b1, svid_pkg::COND_ALWAYS, svid_pkg::OP3_TICC, 5'd31,
                1'b0, 13'h001F});
    send_instr({svid_pkg::OP_ALU, 1'b0, svid_pkg::COND_NEVER, svid_pkg::OP3_TICC, 5'd4,
                1'b0, 13'h0005});
    // Double accesses force an even register pair
    send_instr({svid_pkg::OP_MEM, 5'd31, svid_pkg::OP3_LDD, 5'd31, 1'b0, 13'h1FFF});
    send_instr({svid_pkg::OP_MEM, 5'd1, svid_pkg::OP3_STD, 5'd0, 1'b1, 13'h0000});
    // State register access ignores rs1 and rd respectively
    send_instr({svid_pkg::OP_ALU, 5'd5, svid_pkg::OP3_RDY, 5'd17, 1'b0, 13'h0003});
    send_instr({svid_pkg::OP_ALU, 5'd9, svid_pkg::OP3_WRY, 5'd2, 1'b0, 13'h0004});
    send_instr({svid_pkg::OP_ALU, 5'd30, svid_pkg::OP3_WRPSR, 5'd12, 1'b1, 13'h1ABC});
    send_instr({svid_pkg::OP_ALU, 5'd6, svid_pkg::OP3_MULSCC, 5'd21, 1'b0, 13'h0016});
    send_instr({svid_pkg::OP_MEM, 5'd2, OP3_LDSTUB, 5'd3, 1'b0, 13'h0001});
    send_instr({svid_pkg::OP_MEM, 5'd4, OP3_LDA, 5'd5, 1'b0, 13'h0002});
    send_instr({svid_pkg::OP_ALU, 5'd15, svid_pkg::OP3_JMPL, 5'd31, 1'b1, 13'h0008});
    send_instr({svid_pkg::OP_ALU, 5'd0, svid_pkg::OP3_ADD, 5'd31, 1'b0, 13'h001F});
  endtask

  // Walk every op3 value in both format-3 groups with random operand fields
  task automatic test_opcode_sweep();
    logic [31:0] w;
    gap_max    = 3;
    stall_mode = STALL_LIGHT;
    for (int k = 0; k < 64; k++) begin
      w        = $urandom;
      w[31:30] = svid_pkg::OP_ALU;
      w[24:19] = k[5:0];
      send_instr(w);
      w        = $urandom;
      w[31:30] = svid_pkg::OP_MEM;
      w[24:19] = k[5:0];
      send_instr(w);
    end
  endtask

  // Long random stream; reshuffle pacing and receiver behavior every so often
  task automatic test_random_mix();
    for (int k = 0; k < 500; k++) begin
      if (k % 75 == 0) begin
        stall_mode = stall_mode_t'($urandom_range(3, 0));
        gap_max    = $urandom_range(6, 0);
      end
      send_instr(random_instr());
    end
  endtask

  // Hold the output off long enough that the block fills and stalls its input, then run under heavy random stalls
  task automatic test_output_hold_off();
    gap_max    = 0;
    stall_mode = STALL_NONE;
    hold_len   = 120;
    hold_ask   = ~hold_ask;
    for (int k = 0; k < 40; k++) send_instr(random_instr());
    wait_drained();
    gap_max    = 4;
    stall_mode = STALL_HEAVY;
    for (int k = 0; k < 60; k++) send_instr(random_instr());
  endtask

  // Back-to-back transfers on both sides, then a fixed stall pattern
  task automatic test_full_rate();
    gap_max    = 0;
    stall_mode = STALL_NONE;
    for (int k = 0; k < 250; k++) send_instr(random_instr());
    gap_max    = 2;
    stall_mode = STALL_PATTERN;
    for (int k = 0; k < 100; k++) send_instr(random_instr());
  endtask

  // Receiver: drive out_stall on the falling edge, from the mode or a hold-off
  initial begin : stall_driver
    int unsigned held;
    bit          seen;
    logic [7:0]  pattern;
    out_stall = 1'b0;
    held      = 0;
    seen      = 1'b0;
    pattern   = 8'($urandom);
    if (pattern == 8'h00 || pattern == 8'hFF) pattern = 8'h6C;
    forever begin
      @(negedge clk);
      if (hold_ask != seen) begin
        seen = hold_ask;
        held = hold_len;
      end
      if (held > 0) begin
        held--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(99, 0) < 30);
          STALL_PATTERN: begin
            out_stall <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
          STALL_HEAVY: out_stall <= ($urandom_range(99, 0) < 75);
        endcase
      end
    end
  end

  // Check each output transfer against the oldest outstanding decode
  always @(posedge clk) begin : result_check
    decode_expect_t    e;
    svid_pkg::decode_t got;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_decodes.size() == 0) begin
        report_mismatch("result with no instruction outstanding", 32'h0, 1, 0);
      end else begin
        e   = expected_decodes.pop_front();
        got = {bad, unit, opcode, mem_access, src1_valid, src1_reg, src2_valid,
               src2_reg, dest_mode, dest_reg, dest_pair, flag_use};
        check_field("bad",        e.word, 8'(got.bad),        8'(e.want.bad));
        check_field("unit",       e.word, 8'(got.unit),       8'(e.want.unit));
        check_field("opcode",     e.word, 8'(got.opcode),     8'(e.want.opcode));
        check_field("mem_access", e.word, 8'(got.mem_access), 8'(e.want.mem_access));
        check_field("src1_valid", e.word, 8'(got.src1_valid), 8'(e.want.src1_valid));
        check_field("src1_reg",   e.word, 8'(got.src1_reg),   8'(e.want.src1_reg));
        check_field("src2_valid", e.word, 8'(got.src2_valid), 8'(e.want.src2_valid));
        check_field("src2_reg",   e.word, 8'(got.src2_reg),   8'(e.want.src2_reg));
        check_field("dest_mode",  e.word, 8'(got.dest_mode),  8'(e.want.dest_mode));
        check_field("dest_reg",   e.word, 8'(got.dest_reg),   8'(e.want.dest_reg));
        check_field("dest_pair",  e.word, 8'(got.dest_pair),  8'(e.want.dest_pair));
        check_field("flag_use",   e.word, 8'(got.flag_use),   8'(e.want.flag_use));
      end
    end
  end

  // Watchdog: abort a run that hangs on a handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    instr_word     = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    gap_max        = 0;
    burst_left     = 0;
    stall_mode     = STALL_NONE;
    hold_len       = 0;
    hold_ask       = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_special_cases();
    test_opcode_sweep();
    test_random_mix();
    test_output_hold_off();
    test_full_rate();

    // Release the output, collect everything, then watch for stray results
    stall_mode = STALL_NONE;
    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_decodes.size() != 0)
      report_mismatch("results never delivered", 32'h0, 0, expected_decodes.size());
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
